@@ design/mtx3_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtx3_pkg
// Widths, formats and the job record shared by the 3x3 inverse blocks.
// ----------------------------------------------------------------------------
package mtx3_pkg;

  localparam int IW       = 16;            // element width, Q4.12
  localparam int OW       = 32;            // result width, Q16.16
  localparam int FRAC_IN  = 12;
  localparam int FRAC_OUT = 16;
  localparam int FRAC     = FRAC_IN + FRAC_OUT;
  localparam int PW       = 2 * IW;        // product of two elements
  localparam int AW       = PW + 1;        // adjugate entry
  localparam int DW       = IW + AW + 2;   // determinant
  localparam int NUMW     = AW + FRAC + 1; // rounded scaled numerator
  localparam int QB       = OW + 1;        // quotient bits kept
  localparam int CW       = DW + QB;       // divider compare width
  localparam int NE       = 9;
  localparam int FDEPTH   = 2;

  // adjugate entry k = m[a]*m[b] - m[c]*m[d], element index col*3+row
  localparam int ADJ_IDX [NE][4] = '{
    '{4, 8, 7, 5},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{3, 2, 0, 5},
    '{3, 7, 6, 4},
    '{6, 1, 0, 7},
    '{0, 4, 3, 1}
  };

  typedef struct packed {
    logic                      singular;
    logic [NE-1:0]             neg;
    logic [NE-1:0][NUMW-1:0]   num;
    logic [DW-1:0]             den;
  } mtx3_job_t;

endpackage
`default_nettype wire

@@ design/mtx3_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtx3_front
// Adjugate and determinant pipeline; classifies each matrix into a job.
// ----------------------------------------------------------------------------
module mtx3_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [mtx3_pkg::NE-1:0][mtx3_pkg::IW-1:0] m_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output mtx3_pkg::mtx3_job_t                    job_o
);

  localparam int IW   = mtx3_pkg::IW;
  localparam int PW   = mtx3_pkg::PW;
  localparam int AW   = mtx3_pkg::AW;
  localparam int DW   = mtx3_pkg::DW;
  localparam int NUMW = mtx3_pkg::NUMW;
  localparam int NE   = mtx3_pkg::NE;

  logic [4:0] v_q;
  logic       en;

  logic signed [PW-1:0] pa_q [NE];
  logic signed [PW-1:0] pb_q [NE];
  logic signed [IW-1:0] r1_q [3];
  logic signed [IW-1:0] r2_q [3];
  logic signed [AW-1:0] adj2_q [NE];
  logic signed [AW-1:0] adj3_q [NE];
  logic signed [AW-1:0] adj4_q [NE];
  logic signed [DW-1:0] dp_q [3];
  logic signed [DW-1:0] det_q;
  mtx3_pkg::mtx3_job_t  job_d, job_q;
  logic [DW-1:0]        dmag;
  logic [AW-1:0]        amag;

  assign en      = !(v_q[4] && !ready_i);
  assign ready_o = en;
  assign valid_o = v_q[4];
  assign job_o   = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_comb begin
    dmag  = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    amag  = '0;
    job_d = '0;
    job_d.singular = (det_q == '0);
    job_d.den      = dmag;
    for (int k = 0; k < NE; k++) begin
      amag = adj4_q[k][AW-1] ? AW'(-adj4_q[k]) : AW'(adj4_q[k]);
      job_d.neg[k] = adj4_q[k][AW-1] ^ det_q[DW-1];
      job_d.num[k] = (NUMW'(amag) << mtx3_pkg::FRAC) + NUMW'(dmag >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        pa_q[k] <= $signed(m_i[mtx3_pkg::ADJ_IDX[k][0]])
                 * $signed(m_i[mtx3_pkg::ADJ_IDX[k][1]]);
        pb_q[k] <= $signed(m_i[mtx3_pkg::ADJ_IDX[k][2]])
                 * $signed(m_i[mtx3_pkg::ADJ_IDX[k][3]]);
        adj2_q[k] <= AW'(pa_q[k]) - AW'(pb_q[k]);
        adj3_q[k] <= adj2_q[k];
        adj4_q[k] <= adj3_q[k];
      end
      for (int j = 0; j < 3; j++) begin
        r1_q[j] <= $signed(m_i[j]);
        r2_q[j] <= r1_q[j];
        dp_q[j] <= r2_q[j] * adj2_q[3 * j];
      end
      det_q <= dp_q[0] + dp_q[1] + dp_q[2];
      job_q <= job_d;
    end
  end

endmodule
`default_nettype wire

@@ design/mtx3_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtx3_fifo
// Short job queue between the front and the divider back end.
// ----------------------------------------------------------------------------
module mtx3_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  mtx3_pkg::mtx3_job_t job_i,
  input  logic                pop_i,
  output logic                empty_o,
  output mtx3_pkg::mtx3_job_t job_o
);

  localparam int PTRW = (mtx3_pkg::FDEPTH > 1) ? $clog2(mtx3_pkg::FDEPTH) : 1;
  localparam int CNTW = $clog2(mtx3_pkg::FDEPTH + 1);

  mtx3_pkg::mtx3_job_t mem_q [mtx3_pkg::FDEPTH];
  logic [PTRW-1:0] wp_q, rp_q;
  logic [CNTW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(mtx3_pkg::FDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rp_q];

  function automatic logic [PTRW-1:0] inc(input logic [PTRW-1:0] p);
    inc = (p == PTRW'(mtx3_pkg::FDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= inc(wp_q);
      if (do_pop)  rp_q <= inc(rp_q);
      cnt_q <= cnt_q + CNTW'(do_push) - CNTW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= job_i;
  end

endmodule
`default_nettype wire

@@ design/mtx3_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtx3_back
// Nine pipelined restoring dividers, one quotient bit per stage, then sign
// and saturation into the output register (rounding is added in the front).
// ----------------------------------------------------------------------------
module mtx3_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   empty_i,
  output logic                                   pop_o,
  input  mtx3_pkg::mtx3_job_t                    job_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [mtx3_pkg::NE-1:0][mtx3_pkg::OW-1:0] inv_o,
  output logic                                   singular_o,
  output logic                                   overflow_o
);

  localparam int OW   = mtx3_pkg::OW;
  localparam int QB   = mtx3_pkg::QB;
  localparam int CW   = mtx3_pkg::CW;
  localparam int DW   = mtx3_pkg::DW;
  localparam int NUMW = mtx3_pkg::NUMW;
  localparam int NE   = mtx3_pkg::NE;
  localparam logic [QB-1:0] POS_LIM = QB'((64'd1 << (OW - 1)) - 64'd1);
  localparam logic [QB-1:0] NEG_LIM = QB'(64'd1 << (OW - 1));

  logic                en;
  logic [QB:0]         v_q;
  logic [NUMW-1:0]     rem_q [QB+1][NE];
  logic [QB-1:0]       quo_q [QB+1][NE];
  logic [NE-1:0]       neg_q [QB+1];
  logic [NE-1:0]       big_q [QB+1];
  logic                sing_q [QB+1];
  logic [DW-1:0]       den_q [QB+1];
  logic                out_v_q;
  logic [NE-1:0][OW-1:0] inv_q, inv_d;
  logic                sing_out_q, ovf_q, ovf_d;
  logic [NUMW-1:0]     rem_d [QB][NE];
  logic [QB-1:0]       quo_d [QB][NE];

  assign en         = !out_v_q || ready_i;
  assign pop_o      = en && !empty_i;
  assign valid_o    = out_v_q;
  assign inv_o      = inv_q;
  assign singular_o = sing_out_q;
  assign overflow_o = ovf_q;

  always_comb begin
    for (int s = 0; s < QB; s++) begin
      for (int k = 0; k < NE; k++) begin
        if (CW'(rem_q[s][k]) >= (CW'(den_q[s]) << (QB - 1 - s))) begin
          rem_d[s][k] = NUMW'(CW'(rem_q[s][k]) - (CW'(den_q[s]) << (QB - 1 - s)));
          quo_d[s][k] = {quo_q[s][k][QB-2:0], 1'b1};
        end else begin
          rem_d[s][k] = rem_q[s][k];
          quo_d[s][k] = {quo_q[s][k][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    ovf_d = 1'b0;
    inv_d = '0;
    for (int k = 0; k < NE; k++) begin
      if (sing_q[QB]) begin
        inv_d[k] = '0;
      end else if (!neg_q[QB][k]) begin
        if (big_q[QB][k] || quo_q[QB][k] > POS_LIM) begin
          inv_d[k] = {1'b0, {(OW-1){1'b1}}};
          ovf_d    = 1'b1;
        end else begin
          inv_d[k] = quo_q[QB][k][OW-1:0];
        end
      end else begin
        if (big_q[QB][k] || quo_q[QB][k] > NEG_LIM) begin
          inv_d[k] = {1'b1, {(OW-1){1'b0}}};
          ovf_d    = 1'b1;
        end else begin
          inv_d[k] = OW'(-quo_q[QB][k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q     <= {v_q[QB-1:0], !empty_i};
      out_v_q <= v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        rem_q[0][k] <= job_i.num[k];
        quo_q[0][k] <= '0;
        big_q[0][k] <= CW'(job_i.num[k]) >= (CW'(job_i.den) << QB);
      end
      neg_q[0]  <= job_i.neg;
      sing_q[0] <= job_i.singular;
      den_q[0]  <= job_i.den;
      for (int s = 0; s < QB; s++) begin
        for (int k = 0; k < NE; k++) begin
          rem_q[s+1][k] <= rem_d[s][k];
          quo_q[s+1][k] <= quo_d[s][k];
        end
        neg_q[s+1]  <= neg_q[s];
        big_q[s+1]  <= big_q[s];
        sing_q[s+1] <= sing_q[s];
        den_q[s+1]  <= den_q[s];
      end
      inv_q      <= inv_d;
      sing_out_q <= sing_q[QB];
      ovf_q      <= ovf_d;
    end
  end

endmodule
`default_nettype wire

@@ design/matrix3_inverse.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 matrix inverse by adjugate over determinant, Q4.12 in, Q16.16 out.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  in      | in_valid_i / in_ready_o    | c0_r0_i .. c2_r2_i
//  out     | out_valid_o / out_ready_i  | i0_r0_o .. i2_r2_o, singular_o, overflow_o
//
// One request per cycle sustained while out_ready_i holds; the dividers produce
// one quotient bit per stage (QB = 33) ahead of the output register.
// The front and the dividers stall independently across a two-entry queue.
// Reset clears valid state only.
module matrix3_inverse (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [mtx3_pkg::IW-1:0]   c0_r0_i,
  input  logic [mtx3_pkg::IW-1:0]   c0_r1_i,
  input  logic [mtx3_pkg::IW-1:0]   c0_r2_i,
  input  logic [mtx3_pkg::IW-1:0]   c1_r0_i,
  input  logic [mtx3_pkg::IW-1:0]   c1_r1_i,
  input  logic [mtx3_pkg::IW-1:0]   c1_r2_i,
  input  logic [mtx3_pkg::IW-1:0]   c2_r0_i,
  input  logic [mtx3_pkg::IW-1:0]   c2_r1_i,
  input  logic [mtx3_pkg::IW-1:0]   c2_r2_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mtx3_pkg::OW-1:0]   i0_r0_o,
  output logic [mtx3_pkg::OW-1:0]   i0_r1_o,
  output logic [mtx3_pkg::OW-1:0]   i0_r2_o,
  output logic [mtx3_pkg::OW-1:0]   i1_r0_o,
  output logic [mtx3_pkg::OW-1:0]   i1_r1_o,
  output logic [mtx3_pkg::OW-1:0]   i1_r2_o,
  output logic [mtx3_pkg::OW-1:0]   i2_r0_o,
  output logic [mtx3_pkg::OW-1:0]   i2_r1_o,
  output logic [mtx3_pkg::OW-1:0]   i2_r2_o,
  output logic                      singular_o,
  output logic                      overflow_o
);

  logic [mtx3_pkg::NE-1:0][mtx3_pkg::IW-1:0] m;
  logic [mtx3_pkg::NE-1:0][mtx3_pkg::OW-1:0] inv;
  mtx3_pkg::mtx3_job_t front_job, fifo_job;
  logic front_valid, fifo_full, fifo_empty, pop;

  assign m = {c2_r2_i, c2_r1_i, c2_r0_i, c1_r2_i, c1_r1_i, c1_r0_i,
              c0_r2_i, c0_r1_i, c0_r0_i};

  assign i0_r0_o = inv[0];
  assign i0_r1_o = inv[1];
  assign i0_r2_o = inv[2];
  assign i1_r0_o = inv[3];
  assign i1_r1_o = inv[4];
  assign i1_r2_o = inv[5];
  assign i2_r0_o = inv[6];
  assign i2_r1_o = inv[7];
  assign i2_r2_o = inv[8];

  mtx3_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .m_i     (m),
    .valid_o (front_valid),
    .ready_i (!fifo_full),
    .job_o   (front_job)
  );

  mtx3_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .full_o  (fifo_full),
    .job_i   (front_job),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .job_o   (fifo_job)
  );

  mtx3_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (fifo_empty),
    .pop_o      (pop),
    .job_i      (fifo_job),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .inv_o      (inv),
    .singular_o (singular_o),
    .overflow_o (overflow_o)
  );

endmodule
`default_nettype wire
